[hw/rtl/server_clock_sync_slew_unit_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the server clock sync unit
// Shared helpers so every module writes its checks the same way.
// ----------------------------------------------------------------------------
`ifndef SERVER_CLOCK_SYNC_SLEW_UNIT_DEFINES_SVH
`define SERVER_CLOCK_SYNC_SLEW_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define SCSS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define SCSS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/scss_pkg.sv]
// ----------------------------------------------------------------------------
// scss_pkg
// Shared widths, codes, queue item and divider handshake types.
// ----------------------------------------------------------------------------
package scss_pkg;

  localparam int TickW    = 43;
  localparam int TickOutW = 44;
  localparam int PingW    = 32;
  localparam int StepW    = 30;
  localparam int NsW      = 64;

  localparam int NsPerMs  = 1000000;
  localparam int NsPerMsW = 20;

  localparam logic [StepW-1:0] TickStepReset = 30'd1000000;

  // Top-level parameter defaults
  localparam longint unsigned SlewWindowNs = 64'd1000000000;
  localparam int              QueueDepth   = 4;

  // Quotient bits retired per divider cycle
  localparam int DivDigitBits = 4;

  localparam logic [NsW-1:0] I64Max    = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [NsW-1:0] I64Min    = 64'h8000_0000_0000_0000;
  localparam logic [NsW-1:0] I64MinSat = 64'h8000_0000_0000_0001;

  typedef enum logic [1:0] {
    CMD_SYNC  = 2'd0,
    CMD_TIME  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    OP_SYNC  = 2'd0,
    OP_TIME  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [TickW-1:0]    tick;
    logic [TickOutW-1:0] target;
  } item_t;

  typedef struct packed {
    logic start;
    logic use_window;
  } div_req_t;

  typedef struct packed {
    logic done;
  } div_rsp_t;

  function automatic logic [NsW-1:0] ms_to_ns(input logic [TickOutW-1:0] ms);
    return NsW'(ms) * NsW'(NsPerMs);
  endfunction

  function automatic logic [NsW-1:0] sat_add64(input logic [NsW-1:0] a,
                                               input logic [NsW-1:0] b);
    logic [NsW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[NsW] ? '1 : s[NsW-1:0];
  endfunction

endpackage

[hw/rtl/scss_front.sv]
// ----------------------------------------------------------------------------
// scss_front
// Takes input beats, decodes the command and precomputes the sync target.
// ----------------------------------------------------------------------------
module scss_front import scss_pkg::*; (
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       command_i,
  input  logic [TickW-1:0] server_tick_i,
  input  logic [PingW-1:0] ping_ms_i,
  input  logic             full_i,
  output logic             push_o,
  output item_t            item_o
);

  op_e op;

  always_comb begin
    case (command_i)
      CMD_SYNC:  op = OP_SYNC;
      CMD_TIME:  op = OP_TIME;
      CMD_CLEAR: op = OP_CLEAR;
      default:   op = OP_NOP;
    endcase
  end

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i & ~full_i;

  // target = tick + floor(ping / 2), always fits 44 bits
  assign item_o.op     = op;
  assign item_o.tick   = server_tick_i;
  assign item_o.target = TickOutW'(server_tick_i) + TickOutW'(ping_ms_i[PingW-1:1]);

endmodule

[hw/rtl/scss_queue.sv]
// ----------------------------------------------------------------------------
// scss_queue
// Small flop FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
`include "server_clock_sync_slew_unit_defines.svh"

module scss_queue import scss_pkg::*; #(
  parameter int DEPTH = QueueDepth
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t head_o
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  item_t            mem_q [DEPTH];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;

  function automatic logic [PtrW-1:0] nxt(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= nxt(wr_q);
      if (pop_i)  rd_q <= nxt(rd_q);
      if (push_i && !pop_i)      cnt_q <= cnt_q + CntW'(1);
      else if (!push_i && pop_i) cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

  `SCSS_ASSERT_IMP(a_pop_nonempty, pop_i, cnt_q != '0, "queue popped while empty")

endmodule

[hw/rtl/scss_div.sv]
// ----------------------------------------------------------------------------
// scss_div
// Restoring divider by one of two constants (slew window or 1e6 ns),
// several quotient bits per cycle.
// ----------------------------------------------------------------------------
`include "server_clock_sync_slew_unit_defines.svh"

module scss_div import scss_pkg::*; #(
  parameter longint unsigned SLEW_WINDOW_NS = SlewWindowNs,
  parameter int              DIVIDEND_W     = 96
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  div_req_t              req_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  output div_rsp_t              rsp_o,
  output logic [NsW-1:0]        quot_o
);

  localparam int WinW  = $clog2(SLEW_WINDOW_NS + 1);
  localparam int RemW  = (WinW > NsPerMsW) ? WinW : NsPerMsW;
  localparam int Steps = (DIVIDEND_W + DivDigitBits - 1) / DivDigitBits;
  localparam int PadW  = Steps * DivDigitBits;
  localparam int CntW  = $clog2(Steps + 1);

  localparam logic [RemW-1:0] WinDiv = RemW'(SLEW_WINDOW_NS);
  localparam logic [RemW-1:0] MsDiv  = RemW'(NsPerMs);

  logic            busy_q, done_q, sel_q;
  logic [CntW-1:0] cnt_q;
  logic [RemW-1:0] rem_q, rem_step;
  logic [PadW-1:0] num_q, num_step;

  // DivDigitBits dependent compare/subtract steps
  always_comb begin
    logic [RemW-1:0] divisor;
    logic [RemW:0]   r_ext;
    logic [RemW-1:0] r;
    logic [PadW-1:0] n;
    divisor = sel_q ? WinDiv : MsDiv;
    r = rem_q;
    n = num_q;
    for (int k = 0; k < DivDigitBits; k++) begin
      r_ext = {r, n[PadW-1]};
      n     = {n[PadW-2:0], 1'b0};
      if (r_ext >= {1'b0, divisor}) begin
        r    = RemW'(r_ext - {1'b0, divisor});
        n[0] = 1'b1;
      end else begin
        r = r_ext[RemW-1:0];
      end
    end
    rem_step = r;
    num_step = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(Steps);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= PadW'(dividend_i);
      rem_q <= '0;
      sel_q <= req_i.use_window;
    end else if (busy_q) begin
      num_q <= num_step;
      rem_q <= rem_step;
    end
  end

  assign rsp_o.done = done_q;
  assign quot_o     = num_q[NsW-1:0];

  `SCSS_ASSERT_IMP(a_start_idle, req_i.start, !busy_q, "divider restarted while busy")
  `SCSS_ASSERT_IMP(a_done_after_busy, done_q, $past(busy_q) && !busy_q, "stray divider done")

endmodule

[hw/rtl/scss_back.sv]
// ----------------------------------------------------------------------------
// scss_back
// Clock state, per-item sequencer and output register.
// ----------------------------------------------------------------------------
`include "server_clock_sync_slew_unit_defines.svh"

module scss_back import scss_pkg::*; #(
  parameter longint unsigned SLEW_WINDOW_NS = SlewWindowNs
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [StepW-1:0]    cfg_data_i,
  input  logic                head_valid_i,
  input  item_t               head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [TickOutW-1:0] current_tick_o,
  output logic                synchronized_o
);

  localparam int WinW  = $clog2(SLEW_WINDOW_NS + 1);
  localparam int PpLoW = 32 + WinW;
  localparam int PpHiW = 31 + WinW;
  localparam int ProdW = 63 + WinW;
  localparam int DivW  = (ProdW > NsW) ? ProdW : NsW;

  localparam logic [WinW-1:0] WinVal = WinW'(SLEW_WINDOW_NS);
  localparam logic [NsW-1:0]  WinNs  = NsW'(SLEW_WINDOW_NS);

  typedef enum logic [9:0] {
    ST_IDLE = 10'b00_0000_0001,
    ST_SYNC = 10'b00_0000_0010,
    ST_PREP = 10'b00_0000_0100,
    ST_MLO  = 10'b00_0000_1000,
    ST_MHI  = 10'b00_0001_0000,
    ST_ADD  = 10'b00_0010_0000,
    ST_DIV1 = 10'b00_0100_0000,
    ST_SUM  = 10'b00_1000_0000,
    ST_DIV2 = 10'b01_0000_0000,
    ST_FIN  = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  // Architectural state
  logic [StepW-1:0]    step_q;
  logic [TickW-1:0]    last_q, last_d;
  logic [TickOutW-1:0] est_q, est_d;
  logic [NsW-1:0]      base_q, base_d;
  logic [NsW-1:0]      corr_q, corr_d;
  logic [NsW-1:0]      elapsed_q, elapsed_d;

  // Work registers
  logic [TickOutW-1:0] target_q, target_d;
  logic [NsW-1:0]      tns_q, tns_d, bns_q, bns_d;
  logic                neg_q, neg_d;
  logic [62:0]         mag_q, mag_d, mq_q, mq_d;
  logic [WinW-1:0]     f_q, f_d;
  logic [NsW-1:0]      s_q, s_d;
  logic [PpLoW-1:0]    pp_lo_q, pp_lo_d;
  logic [PpHiW-1:0]    pp_hi_q, pp_hi_d;

  // Output register
  logic                out_valid_q;
  logic [TickOutW-1:0] out_tick_q;
  logic                out_sync_q;

  logic                out_rdy, push;
  logic [TickOutW-1:0] push_tick;

  div_req_t       div_req;
  div_rsp_t       div_rsp;
  logic [DivW-1:0] div_dividend;
  logic [NsW-1:0]  div_quot;

  logic [NsW-1:0]      elapsed_inc, mag_full, corr_sat, s_new;
  logic [NsW:0]        diff, s_pos;
  logic [TickOutW-1:0] tick_clamp;
  logic                win_full;

  assign out_rdy     = !out_valid_q || !out_stall_i;
  assign elapsed_inc = sat_add64(elapsed_q, NsW'(step_q));
  assign mag_full    = corr_q[NsW-1] ? (~corr_q + NsW'(1)) : corr_q;
  assign win_full    = (elapsed_q >= WinNs);
  assign tick_clamp  = (div_quot[NsW-1:TickOutW] != '0) ? '1 : div_quot[TickOutW-1:0];

  // Correction error, saturated to +-(2^63-1)
  assign diff = {1'b0, tns_q} - {1'b0, bns_q};
  always_comb begin
    if (!diff[NsW] && diff[NsW-1]) begin
      corr_sat = I64Max;
    end else if (diff[NsW] && (!diff[NsW-1] || diff[NsW-1:0] == I64Min)) begin
      corr_sat = I64MinSat;
    end else begin
      corr_sat = diff[NsW-1:0];
    end
  end

  // base + elapsed +- slewed correction, clamped to [0, 2^64-1]
  assign s_pos = {1'b0, s_q} + (NsW+1)'(mq_q);
  always_comb begin
    if (neg_q) begin
      s_new = (s_q < NsW'(mq_q)) ? '0 : s_q - NsW'(mq_q);
    end else begin
      s_new = s_pos[NsW] ? '1 : s_pos[NsW-1:0];
    end
  end

  always_comb begin
    state_d      = state_q;
    last_d       = last_q;
    est_d        = est_q;
    base_d       = base_q;
    corr_d       = corr_q;
    elapsed_d    = elapsed_q;
    target_d     = target_q;
    tns_d        = tns_q;
    bns_d        = bns_q;
    neg_d        = neg_q;
    mag_d        = mag_q;
    mq_d         = mq_q;
    f_d          = f_q;
    s_d          = s_q;
    pp_lo_d      = pp_lo_q;
    pp_hi_d      = pp_hi_q;
    pop_o        = 1'b0;
    push         = 1'b0;
    push_tick    = est_q;
    div_req      = '0;
    div_dividend = '0;

    case (state_q)
      ST_IDLE: begin
        if (head_valid_i) begin
          case (head_i.op)
            OP_SYNC: begin
              if (head_i.tick > last_q) begin
                pop_o     = 1'b1;
                last_d    = head_i.tick;
                elapsed_d = '0;
                target_d  = head_i.target;
                tns_d     = ms_to_ns(head_i.target);
                bns_d     = ms_to_ns(est_q);
                state_d   = ST_SYNC;
              end else if (out_rdy) begin
                pop_o = 1'b1;
                push  = 1'b1;
              end
            end
            OP_TIME: begin
              if (est_q != '0) begin
                pop_o     = 1'b1;
                elapsed_d = elapsed_inc;
                state_d   = ST_PREP;
              end else if (out_rdy) begin
                pop_o     = 1'b1;
                elapsed_d = elapsed_inc;
                push      = 1'b1;
              end
            end
            OP_CLEAR: begin
              if (out_rdy) begin
                pop_o     = 1'b1;
                push      = 1'b1;
                push_tick = '0;
                last_d    = '0;
                est_d     = '0;
                corr_d    = '0;
                elapsed_d = '0;
              end
            end
            default: begin
              if (out_rdy) begin
                pop_o = 1'b1;
                push  = 1'b1;
              end
            end
          endcase
        end
      end
      ST_SYNC: begin
        if (out_rdy) begin
          push = 1'b1;
          if (est_q == '0) begin
            est_d     = target_q;
            base_d    = tns_q;
            corr_d    = '0;
            push_tick = target_q;
          end else begin
            base_d = bns_q;
            corr_d = corr_sat;
          end
          state_d = ST_IDLE;
        end
      end
      ST_PREP: begin
        neg_d = corr_q[NsW-1];
        mag_d = mag_full[62:0];
        f_d   = win_full ? WinVal : elapsed_q[WinW-1:0];
        s_d   = sat_add64(base_q, elapsed_q);
        // past the window, or nothing to slew: no multiply or window divide needed
        if (win_full || corr_q == '0) begin
          mq_d    = win_full ? mag_full[62:0] : '0;
          state_d = ST_SUM;
        end else begin
          state_d = ST_MLO;
        end
      end
      ST_MLO: begin
        pp_lo_d = PpLoW'(mag_q[31:0]) * PpLoW'(f_q);
        state_d = ST_MHI;
      end
      ST_MHI: begin
        pp_hi_d = PpHiW'(mag_q[62:32]) * PpHiW'(f_q);
        state_d = ST_ADD;
      end
      ST_ADD: begin
        div_req.start      = 1'b1;
        div_req.use_window = 1'b1;
        div_dividend       = (DivW'(pp_hi_q) << 32) + DivW'(pp_lo_q);
        state_d            = ST_DIV1;
      end
      ST_DIV1: begin
        if (div_rsp.done) begin
          mq_d    = div_quot[62:0];
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        div_req.start      = 1'b1;
        div_req.use_window = 1'b0;
        div_dividend       = DivW'(s_new);
        state_d            = ST_DIV2;
      end
      ST_DIV2: begin
        if (div_rsp.done) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_rdy) begin
          est_d     = tick_clamp;
          push      = 1'b1;
          push_tick = tick_clamp;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= TickStepReset;
      last_q      <= '0;
      est_q       <= '0;
      corr_q      <= '0;
      elapsed_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      last_q    <= last_d;
      est_q     <= est_d;
      corr_q    <= corr_d;
      elapsed_q <= elapsed_d;
      if (cfg_valid_i) step_q <= cfg_data_i;
      if (push)              out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q   <= base_d;
    target_q <= target_d;
    tns_q    <= tns_d;
    bns_q    <= bns_d;
    neg_q    <= neg_d;
    mag_q    <= mag_d;
    mq_q     <= mq_d;
    f_q      <= f_d;
    s_q      <= s_d;
    pp_lo_q  <= pp_lo_d;
    pp_hi_q  <= pp_hi_d;
    if (push) begin
      out_tick_q <= push_tick;
      out_sync_q <= (push_tick != '0);
    end
  end

  scss_div #(
    .SLEW_WINDOW_NS (SLEW_WINDOW_NS),
    .DIVIDEND_W     (DivW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (div_dividend),
    .rsp_o      (div_rsp),
    .quot_o     (div_quot)
  );

  assign out_valid_o    = out_valid_q;
  assign current_tick_o = out_tick_q;
  assign synchronized_o = out_sync_q;

  `SCSS_ASSERT_IMP(a_est_needs_sync, last_q == '0, est_q == '0, "estimate set without sync")
  `SCSS_ASSERT_IMP(a_corr_in_range, 1'b1, corr_q != I64Min, "correction not saturated")
  `SCSS_ASSERT_IMP(a_pop_in_idle, pop_o, state_q == ST_IDLE, "queue popped mid item")

endmodule

[hw/rtl/server_clock_sync_slew_unit.sv]
// ----------------------------------------------------------------------------
// server_clock_sync_slew_unit
// Local estimate of a remote server's millisecond tick, slewed toward each
// new sync point over a fixed window of local time.
// ----------------------------------------------------------------------------
// Every input beat (sync, time, reset; code 3 is a no-op) returns exactly one
// result beat with the estimated tick after that beat and a synchronized flag
// (tick nonzero). Input beats are taken one per clock while the QUEUE_DEPTH
// entry queue has room; results leave through an output register, so a
// stalled output does not block intake until the queue fills. The back end
// retires a reset, no-op, stale sync or an unsynchronized time beat from
// idle and a fresh sync through the SYNC state. For a time beat while
// synchronized (W = 30 bits for the default 1 s window), the slewed
// correction needs a 63xW product divided by the window, and the
// nanosecond sum divided by 1e6, both on one shared restoring divider that
// retires 4 quotient bits per cycle. Once elapsed time reaches the window,
// or the correction is zero, the multiply and first division are skipped.
// tick_step_ns is written through the cfg port, which is always ready;
// write it only while no beat is in flight.
// ----------------------------------------------------------------------------
module server_clock_sync_slew_unit import scss_pkg::*; #(
  parameter longint unsigned SLEW_WINDOW_NS = SlewWindowNs,
  parameter int              QUEUE_DEPTH    = QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,

  // configuration write channel (tick_step_ns)
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [StepW-1:0]    cfg_data_i,

  // input beats
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          command_i,
  input  logic [TickW-1:0]    server_tick_i,
  input  logic [PingW-1:0]    ping_ms_i,

  // result beats
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [TickOutW-1:0] current_tick_o,
  output logic                synchronized_o
);

  logic  q_full, q_push, q_pop, q_valid;
  item_t q_in, q_head;

  // Register write lands in step_q at the next clock edge; never back-pressured.
  assign cfg_ready_o = 1'b1;

  // Front: decode command, precompute tick + ping/2
  scss_front u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .server_tick_i (server_tick_i),
    .ping_ms_i     (ping_ms_i),
    .full_i        (q_full),
    .push_o        (q_push),
    .item_o        (q_in)
  );

  // Decouples intake from the multi-cycle back end
  scss_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .head_o  (q_head)
  );

  // Back: clock state, slew arithmetic, result register
  scss_back #(
    .SLEW_WINDOW_NS (SLEW_WINDOW_NS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .head_valid_i   (q_valid),
    .head_i         (q_head),
    .pop_o          (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .current_tick_o (current_tick_o),
    .synchronized_o (synchronized_o)
  );

endmodule
